// ----- sv/lox_token_scanner_macros.svh -----
// Assertion shorthands for the scanner checker.
`ifndef LOX_TOKEN_SCANNER_MACROS_SVH
`define LOX_TOKEN_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lts_pkg.sv -----
package lts_pkg;

  localparam int OUT_LINE_BITS = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef enum logic [4:0] {
    TK_LEFT_PAREN    = 5'd0,
    TK_RIGHT_PAREN   = 5'd1,
    TK_LEFT_BRACE    = 5'd2,
    TK_RIGHT_BRACE   = 5'd3,
    TK_COMMA         = 5'd4,
    TK_DOT           = 5'd5,
    TK_MINUS         = 5'd6,
    TK_PLUS          = 5'd7,
    TK_SEMICOLON     = 5'd8,
    TK_STAR          = 5'd9,
    TK_BANG          = 5'd10,
    TK_BANG_EQUAL    = 5'd11,
    TK_EQUAL         = 5'd12,
    TK_EQUAL_EQUAL   = 5'd13,
    TK_LESS          = 5'd14,
    TK_LESS_EQUAL    = 5'd15,
    TK_GREATER       = 5'd16,
    TK_GREATER_EQUAL = 5'd17,
    TK_SLASH         = 5'd18,
    TK_EOF           = 5'd19,
    TK_ERROR         = 5'd20
  } tok_kind_t;

  typedef enum logic [2:0] {
    PEND_NONE    = 3'd0,
    PEND_BANG    = 3'd1,
    PEND_EQUAL   = 3'd2,
    PEND_LESS    = 3'd3,
    PEND_GREATER = 3'd4,
    PEND_SLASH   = 3'd5
  } pend_t;

  typedef enum logic [1:0] {
    CM_NORMAL = 2'd0,
    CM_LINE   = 2'd1,
    CM_BLOCK  = 2'd2,
    CM_STAR   = 2'd3
  } cmode_t;

  typedef enum logic [1:0] {
    ACT_TOKEN,
    ACT_HOLD,
    ACT_NEWLINE,
    ACT_ERROR
  } act_t;

  typedef struct packed {
    act_t      act;
    tok_kind_t kind;
    pend_t     pend;
  } cls_t;

  // Packed so that token_kind lands in the lowest bits.
  typedef struct packed {
    logic                     any_error;
    logic [OUT_LINE_BITS-1:0] line_number;
    logic [7:0]               bad_byte;
    tok_kind_t                token_kind;
  } result_t;

  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     slot;
  } bundle_t;

  function automatic cls_t classify(logic [7:0] c);
    cls_t r;
    r.act  = ACT_TOKEN;
    r.kind = TK_ERROR;
    r.pend = PEND_NONE;
    unique case (c)
      CH_LPAREN:  r.kind = TK_LEFT_PAREN;
      CH_RPAREN:  r.kind = TK_RIGHT_PAREN;
      CH_LBRACE:  r.kind = TK_LEFT_BRACE;
      CH_RBRACE:  r.kind = TK_RIGHT_BRACE;
      CH_COMMA:   r.kind = TK_COMMA;
      CH_DOT:     r.kind = TK_DOT;
      CH_MINUS:   r.kind = TK_MINUS;
      CH_PLUS:    r.kind = TK_PLUS;
      CH_SEMI:    r.kind = TK_SEMICOLON;
      CH_STAR:    r.kind = TK_STAR;
      CH_BANG:    begin r.act = ACT_HOLD; r.pend = PEND_BANG;    end
      CH_EQUAL:   begin r.act = ACT_HOLD; r.pend = PEND_EQUAL;   end
      CH_LESS:    begin r.act = ACT_HOLD; r.pend = PEND_LESS;    end
      CH_GREATER: begin r.act = ACT_HOLD; r.pend = PEND_GREATER; end
      CH_SLASH:   begin r.act = ACT_HOLD; r.pend = PEND_SLASH;   end
      CH_NEWLINE: r.act = ACT_NEWLINE;
      default:    r.act = ACT_ERROR;
    endcase
    return r;
  endfunction

  function automatic tok_kind_t single_kind(pend_t p);
    tok_kind_t k;
    unique case (p)
      PEND_BANG:    k = TK_BANG;
      PEND_EQUAL:   k = TK_EQUAL;
      PEND_LESS:    k = TK_LESS;
      PEND_GREATER: k = TK_GREATER;
      default:      k = TK_SLASH;
    endcase
    return k;
  endfunction

  function automatic tok_kind_t double_kind(pend_t p);
    tok_kind_t k;
    unique case (p)
      PEND_BANG:    k = TK_BANG_EQUAL;
      PEND_EQUAL:   k = TK_EQUAL_EQUAL;
      PEND_LESS:    k = TK_LESS_EQUAL;
      default:      k = TK_GREATER_EQUAL;
    endcase
    return k;
  endfunction

endpackage

// ----- sv/lts_front.sv -----
module lts_front import lts_pkg::*; #(
  parameter int LINE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       in_ready,
  input  logic       queue_full,
  output logic       push,
  output bundle_t    push_data
);

  pend_t                pending, pending_next;
  cmode_t               mode, mode_next;
  logic [LINE_BITS-1:0] line, line_next;
  logic                 err, err_next;

  logic                 accept;
  result_t [2:0]        slots;
  logic [1:0]           n;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pend_t                p;
    cmode_t               m;
    logic [LINE_BITS-1:0] ln;
    logic                 e;
    logic                 fresh;
    cls_t                 cls;
    p     = pending;
    m     = mode;
    ln    = line;
    e     = err;
    fresh = 1'b0;
    n     = 2'd0;
    slots = '0;
    cls   = classify(in_byte);

    unique case (m)
      CM_LINE: begin
        if (in_byte == CH_NEWLINE) begin
          ln = (ln == '1) ? ln : ln + LINE_BITS'(1);
          m  = CM_NORMAL;
        end
      end
      CM_BLOCK, CM_STAR: begin
        if (m == CM_STAR && in_byte == CH_SLASH) begin
          m = CM_NORMAL;
        end else if (in_byte == CH_STAR) begin
          m = CM_STAR;
        end else begin
          if (in_byte == CH_NEWLINE) begin
            ln = (ln == '1) ? ln : ln + LINE_BITS'(1);
          end
          m = CM_BLOCK;
        end
      end
      default: begin
        if (p == PEND_SLASH) begin
          p = PEND_NONE;
          if (in_byte == CH_SLASH) begin
            m = CM_LINE;
          end else if (in_byte == CH_STAR) begin
            m = CM_BLOCK;
          end else begin
            slots[n] = '{1'b0, OUT_LINE_BITS'(ln), 8'd0, TK_SLASH};
            n = n + 2'd1;
            fresh = 1'b1;
          end
        end else if (p != PEND_NONE) begin
          if (in_byte == CH_EQUAL) begin
            slots[n] = '{1'b0, OUT_LINE_BITS'(ln), 8'd0, double_kind(p)};
          end else begin
            slots[n] = '{1'b0, OUT_LINE_BITS'(ln), 8'd0, single_kind(p)};
            fresh = 1'b1;
          end
          n = n + 2'd1;
          p = PEND_NONE;
        end else begin
          fresh = 1'b1;
        end
      end
    endcase

    if (fresh) begin
      unique case (cls.act)
        ACT_TOKEN: begin
          slots[n] = '{1'b0, OUT_LINE_BITS'(ln), 8'd0, cls.kind};
          n = n + 2'd1;
        end
        ACT_HOLD: p = cls.pend;
        ACT_NEWLINE: ln = (ln == '1) ? ln : ln + LINE_BITS'(1);
        default: begin
          slots[n] = '{1'b0, OUT_LINE_BITS'(ln), in_byte, TK_ERROR};
          n = n + 2'd1;
          e = 1'b1;
        end
      endcase
    end

    if (in_last) begin
      if (p != PEND_NONE) begin
        slots[n] = '{1'b0, OUT_LINE_BITS'(ln), 8'd0, single_kind(p)};
        n = n + 2'd1;
      end
      slots[n] = '{e, OUT_LINE_BITS'(ln), 8'd0, TK_EOF};
      n = n + 2'd1;
      // A finished file leaves the scanner as after reset.
      p  = PEND_NONE;
      m  = CM_NORMAL;
      ln = LINE_BITS'(1);
      e  = 1'b0;
    end

    pending_next = p;
    mode_next    = m;
    line_next    = ln;
    err_next     = e;
  end

  assign push            = accept && (n != 2'd0);
  assign push_data.count = n;
  assign push_data.slot  = slots;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= PEND_NONE;
      mode    <= CM_NORMAL;
      line    <= LINE_BITS'(1);
      err     <= 1'b0;
    end else if (accept) begin
      pending <= pending_next;
      mode    <= mode_next;
      line    <= line_next;
      err     <= err_next;
    end
  end

endmodule

// ----- sv/lts_fifo.sv -----
module lts_fifo import lts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output bundle_t pop_data,
  output logic    empty
);

  bundle_t              entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full     = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

endmodule

// ----- sv/lts_back.sv -----
module lts_back import lts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        queue_empty,
  input  bundle_t     queue_data,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic        m_tlast
);

  bundle_t    cur;
  logic       have;
  logic [1:0] idx;
  logic       taking;
  logic       at_end;
  result_t    shown;

  assign shown    = cur.slot[idx];
  assign at_end   = (idx == cur.count - 2'd1);
  assign taking   = have && m_tready;
  assign pop      = !queue_empty && (!have || (taking && at_end));

  assign m_tvalid = have;
  assign m_tdata  = {2'b00, shown};
  assign m_tlast  = at_end;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= queue_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      have <= 1'b1;
      idx  <= 2'd0;
    end else if (taking && at_end) begin
      have <= 1'b0;
      idx  <= 2'd0;
    end else if (taking) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

// ----- sv/lox_token_scanner.sv -----
// Operator-subset scanner for Lox source text.
// Input stream: one source byte per word on s_tdata; s_tlast marks the last
// byte of a file. Output stream: one token per word on m_tdata; m_tlast marks
// the final token caused by one input byte.
// A byte yields zero to three tokens. The ten single-character operators come
// out at once; ! = < > / are held until the next byte decides between one and
// two characters or a comment opener. Comments and newlines yield nothing;
// any other byte, whitespace too, yields an error token with the byte and its
// line. On the last byte a held operator is flushed and an end-of-file token
// carries the file's error flag; the scanner then starts the next file fresh.
// A token passes through a queue entry and then the output sequencer's bundle
// register before it is shown on m_tvalid.
// Throughput: one byte per cycle in while the queue is not full; the output
// side sends one token per cycle while m_tready is high, so a byte with two or three tokens keeps it busy longer.
// A four-entry queue between the scanning front and the output sequencer
// absorbs such bursts and output stalls; s_tready falls only when it is full.
// Reset clears the scanner state, line count to one, and empties the queue.
module lox_token_scanner import lts_pkg::*; #(
  parameter int LINE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] in_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [4:0] token_kind, [12:5] bad_byte, [28:13] line_number, [29] any_error
  output logic [31:0] m_tdata,
  output logic        m_tlast
);

  logic    push;
  logic    pop;
  logic    full;
  logic    empty;
  bundle_t push_data;
  bundle_t pop_data;

  lts_front #(
    .LINE_BITS(LINE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .in_ready  (s_tready),
    .queue_full(full),
    .push      (push),
    .push_data (push_data)
  );

  lts_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .pop_data (pop_data),
    .empty    (empty)
  );

  lts_back u_back (
    .clk        (clk),
    .rst        (rst),
    .queue_empty(empty),
    .queue_data (pop_data),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

// ----- sv/lts_checker.sv -----
`include "lox_token_scanner_macros.svh"

module lts_checker import lts_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  `LTS_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")

  `LTS_ASSERT_NOW(a_eof_last, clk, rst, m_tvalid && m_tdata[4:0] == TK_EOF,
    m_tlast, "end-of-file token is not the final token of its byte")

  `LTS_ASSERT_NOW(a_bad_zero, clk, rst, m_tvalid && m_tdata[4:0] != TK_ERROR,
    m_tdata[12:5] == 8'd0, "bad byte set on a non-error token")

  `LTS_ASSERT_NOW(a_flag_eof, clk, rst, m_tvalid && m_tdata[29],
    m_tdata[4:0] == TK_EOF, "error flag set on a token other than end of file")

endmodule

bind lox_token_scanner lts_checker u_lts_checker (.*);
